### rtl/tlpc_pkg.sv
`timescale 1ns / 1ps

package tlpc_pkg;

   localparam int MAP_COLUMNS      = 80;
   localparam int MAP_ROWS         = 40;
   localparam int MAP_ENTRIES      = MAP_COLUMNS * MAP_ROWS;
   localparam int TILE_SIZE        = 16;
   localparam int TILE_STORE_BYTES = 65536;
   localparam int PALETTE_ENTRIES  = 256;
   localparam int BYTES_PER_TILE   = 256;
   localparam int WRAP_W           = 1280;
   localparam int WRAP_H           = 640;

   localparam int MAP_AW  = $clog2(MAP_ENTRIES);
   localparam int TILE_AW = $clog2(TILE_STORE_BYTES);
   localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);

   typedef logic [2:0] op_type;
   localparam op_type OP_RENDER   = 3'd0;
   localparam op_type OP_WR_MAP0  = 3'd1;
   localparam op_type OP_WR_MAP1  = 3'd2;
   localparam op_type OP_WR_TILE  = 3'd3;
   localparam op_type OP_WR_PAL   = 3'd4;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_VIDEO_MODE = 3'd0;
   localparam csr_index_type CSR_L0_SCROLL_X = 3'd1;
   localparam csr_index_type CSR_L0_SCROLL_Y = 3'd2;
   localparam csr_index_type CSR_L1_SCROLL_X = 3'd3;
   localparam csr_index_type CSR_L1_SCROLL_Y = 3'd4;

   // Screen column plus scroll, wrapped at the map width (sum stays below 3 * WRAP_W).
   function automatic logic [10:0] wrap_x(input logic [9:0] x, input logic [10:0] s);
      logic [11:0] sum;
      sum = {1'b0, s} + {2'b0, x};
      if (sum >= 12'(2 * WRAP_W)) begin
         wrap_x = 11'(sum - 12'(2 * WRAP_W));
      end else if (sum >= 12'(WRAP_W)) begin
         wrap_x = 11'(sum - 12'(WRAP_W));
      end else begin
         wrap_x = 11'(sum);
      end
   endfunction

   // Screen row plus scroll, wrapped at the map height (sum stays below 4 * WRAP_H).
   function automatic logic [9:0] wrap_y(input logic [8:0] y, input logic [10:0] s);
      logic [11:0] sum;
      sum = {1'b0, s} + {3'b0, y};
      if (sum >= 12'(3 * WRAP_H)) begin
         wrap_y = 10'(sum - 12'(3 * WRAP_H));
      end else if (sum >= 12'(2 * WRAP_H)) begin
         wrap_y = 10'(sum - 12'(2 * WRAP_H));
      end else if (sum >= 12'(WRAP_H)) begin
         wrap_y = 10'(sum - 12'(WRAP_H));
      end else begin
         wrap_y = 10'(sum);
      end
   endfunction

   // Tile column plus tile row times 80, as 64 + 16.
   function automatic logic [MAP_AW-1:0] map_index(input logic [6:0] tx, input logic [5:0] ty);
      map_index = {5'b0, tx} + {ty, 6'b0} + {2'b0, ty, 4'b0};
   endfunction

endpackage

### rtl/tlpc_ifs.sv
`timescale 1ns / 1ps

interface tlpc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [15:0] addr;
   logic [15:0] wdata;
   logic [9:0]  pixel_x;
   logic [8:0]  pixel_y;
   logic [15:0] sprite_color;
   logic        sprite_behind;

   modport source (output valid, op, addr, wdata, pixel_x, pixel_y, sprite_color,
                   sprite_behind, input ready);
   modport sink   (input valid, op, addr, wdata, pixel_x, pixel_y, sprite_color,
                   sprite_behind, output ready);
endinterface

interface tlpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  out_x;
   logic [8:0]  out_y;
   logic [15:0] pixel_color;

   modport source (output valid, out_x, out_y, pixel_color, input ready);
   modport sink   (input valid, out_x, out_y, pixel_color, output ready);
endinterface

interface tlpc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [10:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/tlpc_ram.sv
`timescale 1ns / 1ps

module tlpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tile_layer_pixel_compositor_top.sv
`timescale 1ns / 1ps

// Two-layer scrolling tile map compositor with sprite priority.
// Channels:
//   req_bus  - requests: op 0 renders one pixel, ops 1..4 write map 0, map 1,
//              tile store and palette. Writes give no response; renders off
//              the current mode's screen and unused ops are dropped.
//   rsp_bus  - one response per visible render: position and RGB565 color,
//              in request order.
//   csr_bus  - register writes (video mode, layer scroll). Always ready; write
//              only while no request is in flight.
// Timing: five-stage pipeline (wrap, map read, tile read, palette read,
//   output register). A new request may be accepted every cycle unless
//   the output stalls. Stage depth is set by the three registered memory
//   reads in series.
// Stalls: while a response waits and rsp_bus.ready is low, the whole pipeline
//   holds, memory read registers included, and req_bus.ready drops.
// Reset: clears registers and stage valid bits. The stores are not cleared;
//   they must be written before they are read, so no clearing pass is run.
module tile_layer_pixel_compositor_top import tlpc_pkg::*; (
   input logic         clock,
   input logic         reset,
   tlpc_req_if.sink    req_bus,
   tlpc_rsp_if.source  rsp_bus,
   tlpc_csr_if.sink    csr_bus
);

   // ---------------------------------------------------------------- registers
   logic [1:0]  video_mode_ff;
   logic [10:0] l0_sx_ff, l0_sy_ff, l1_sx_ff, l1_sy_ff;
   logic        narrow, four;

   assign csr_bus.ready = 1'b1;
   assign narrow = video_mode_ff[0];
   assign four   = video_mode_ff[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         video_mode_ff <= '0;
         l0_sx_ff      <= '0;
         l0_sy_ff      <= '0;
         l1_sx_ff      <= '0;
         l1_sy_ff      <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_VIDEO_MODE:  video_mode_ff <= csr_bus.data[1:0];
            CSR_L0_SCROLL_X: l0_sx_ff      <= csr_bus.data;
            CSR_L0_SCROLL_Y: l0_sy_ff      <= csr_bus.data;
            CSR_L1_SCROLL_X: l1_sx_ff      <= csr_bus.data;
            CSR_L1_SCROLL_Y: l1_sy_ff      <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // One enable moves every stage; it is low only while a response is refused.
   logic adv;
   logic rsp_valid_ff;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // ---------------------------------------------------------------- stage 0: filter, wrap
   logic in_range, keep, s1_valid_in;

   always_comb begin
      in_range = narrow ? (req_bus.pixel_x < 10'd320 && req_bus.pixel_y < 9'd240)
                        : (req_bus.pixel_x < 10'd640 && req_bus.pixel_y < 9'd480);
      case (req_bus.op) inside
         OP_RENDER:                                     keep = in_range;
         OP_WR_MAP0, OP_WR_MAP1, OP_WR_TILE, OP_WR_PAL: keep = 1'b1;
         default:                                       keep = 1'b0;
      endcase
   end

   assign s1_valid_in = req_bus.valid && keep;

   logic        s1_valid_ff;
   op_type      s1_op_ff;
   logic [15:0] s1_addr_ff, s1_wdata_ff, s1_spr_ff;
   logic [9:0]  s1_x_ff;
   logic [8:0]  s1_y_ff;
   logic        s1_behind_ff;
   logic [10:0] s1_wx0_ff, s1_wx1_ff;
   logic [9:0]  s1_wy0_ff, s1_wy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff     <= req_bus.op;
         s1_addr_ff   <= req_bus.addr;
         s1_wdata_ff  <= req_bus.wdata;
         s1_spr_ff    <= req_bus.sprite_color;
         s1_behind_ff <= req_bus.sprite_behind;
         s1_x_ff      <= req_bus.pixel_x;
         s1_y_ff      <= req_bus.pixel_y;
         s1_wx0_ff    <= wrap_x(req_bus.pixel_x, l0_sx_ff);
         s1_wy0_ff    <= wrap_y(req_bus.pixel_y, l0_sy_ff);
         s1_wx1_ff    <= wrap_x(req_bus.pixel_x, l1_sx_ff);
         s1_wy1_ff    <= wrap_y(req_bus.pixel_y, l1_sy_ff);
      end
   end

   // ---------------------------------------------------------------- stage 1: map read
   // In 4-bit mode map 1 holds attributes at layer 0's map position.
   logic [MAP_AW-1:0] idx0, idx1, map1_rd_addr;
   logic              map0_we, map1_we, map_addr_ok;
   logic [7:0]        t0, t1;

   assign idx0         = map_index(s1_wx0_ff[10:4], s1_wy0_ff[9:4]);
   assign idx1         = map_index(s1_wx1_ff[10:4], s1_wy1_ff[9:4]);
   assign map1_rd_addr = four ? idx0 : idx1;
   assign map_addr_ok  = s1_addr_ff < 16'(MAP_ENTRIES);
   assign map0_we      = adv && s1_valid_ff && s1_op_ff == OP_WR_MAP0 && map_addr_ok;
   assign map1_we      = adv && s1_valid_ff && s1_op_ff == OP_WR_MAP1 && map_addr_ok;

   tlpc_ram #(.WIDTH(8), .DEPTH(MAP_ENTRIES)) u_map0 (
      .clock   (clock),
      .wr_en   (map0_we),
      .wr_addr (s1_addr_ff[MAP_AW-1:0]),
      .wr_data (s1_wdata_ff[7:0]),
      .rd_en   (adv),
      .rd_addr (idx0),
      .rd_data (t0)
   );

   tlpc_ram #(.WIDTH(8), .DEPTH(MAP_ENTRIES)) u_map1 (
      .clock   (clock),
      .wr_en   (map1_we),
      .wr_addr (s1_addr_ff[MAP_AW-1:0]),
      .wr_data (s1_wdata_ff[7:0]),
      .rd_en   (adv),
      .rd_addr (map1_rd_addr),
      .rd_data (t1)
   );

   logic        s2_valid_ff;
   op_type      s2_op_ff;
   logic [15:0] s2_addr_ff, s2_wdata_ff, s2_spr_ff;
   logic [9:0]  s2_x_ff;
   logic [8:0]  s2_y_ff;
   logic        s2_behind_ff;
   logic [3:0]  s2_ox0_ff, s2_oy0_ff, s2_ox1_ff, s2_oy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_op_ff     <= s1_op_ff;
         s2_addr_ff   <= s1_addr_ff;
         s2_wdata_ff  <= s1_wdata_ff;
         s2_spr_ff    <= s1_spr_ff;
         s2_behind_ff <= s1_behind_ff;
         s2_x_ff      <= s1_x_ff;
         s2_y_ff      <= s1_y_ff;
         s2_ox0_ff    <= s1_wx0_ff[3:0];
         s2_oy0_ff    <= s1_wy0_ff[3:0];
         s2_ox1_ff    <= s1_wx1_ff[3:0];
         s2_oy1_ff    <= s1_wy1_ff[3:0];
      end
   end

   // ---------------------------------------------------------------- stage 2: tile read
   // 4-bit: attribute bit 0 extends the tile number, bits 2/3 flip y/x, and
   // two pixels share a byte. The tile store is kept twice, one copy per layer.
   logic [3:0]         ox4, oy4;
   logic [16:0]        nib_addr;
   logic [TILE_AW-1:0] tile_a_addr, tile_b_addr;
   logic               tile_we;
   logic [7:0]         ca, cb;

   assign oy4         = t1[2] ? ~s2_oy0_ff : s2_oy0_ff;
   assign ox4         = t1[3] ? ~s2_ox0_ff : s2_ox0_ff;
   assign nib_addr    = {t1[0], t0, oy4, ox4};
   assign tile_a_addr = four ? nib_addr[16:1] : {t0, s2_oy0_ff, s2_ox0_ff};
   assign tile_b_addr = {t1, s2_oy1_ff, s2_ox1_ff};
   assign tile_we     = adv && s2_valid_ff && s2_op_ff == OP_WR_TILE;

   tlpc_ram #(.WIDTH(8), .DEPTH(TILE_STORE_BYTES)) u_tile_a (
      .clock   (clock),
      .wr_en   (tile_we),
      .wr_addr (s2_addr_ff),
      .wr_data (s2_wdata_ff[7:0]),
      .rd_en   (adv),
      .rd_addr (tile_a_addr),
      .rd_data (ca)
   );

   tlpc_ram #(.WIDTH(8), .DEPTH(TILE_STORE_BYTES)) u_tile_b (
      .clock   (clock),
      .wr_en   (tile_we),
      .wr_addr (s2_addr_ff),
      .wr_data (s2_wdata_ff[7:0]),
      .rd_en   (adv),
      .rd_addr (tile_b_addr),
      .rd_data (cb)
   );

   logic        s3_valid_ff;
   op_type      s3_op_ff;
   logic [15:0] s3_addr_ff, s3_wdata_ff, s3_spr_ff;
   logic [9:0]  s3_x_ff;
   logic [8:0]  s3_y_ff;
   logic        s3_behind_ff;
   logic [3:0]  s3_attr_hi_ff;
   logic        s3_nib_lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_op_ff      <= s2_op_ff;
         s3_addr_ff    <= s2_addr_ff;
         s3_wdata_ff   <= s2_wdata_ff;
         s3_spr_ff     <= s2_spr_ff;
         s3_behind_ff  <= s2_behind_ff;
         s3_x_ff       <= s2_x_ff;
         s3_y_ff       <= s2_y_ff;
         s3_attr_hi_ff <= t1[7:4];
         s3_nib_lo_ff  <= nib_addr[0];
      end
   end

   // ---------------------------------------------------------------- stage 3: palette read
   // Even pixel takes the high nibble; the attribute's high nibble offsets it.
   logic [3:0]        nib;
   logic              opaque;
   logic [PAL_AW-1:0] pal_rd_addr;
   logic              pal_we;
   logic [15:0]       pal_color;

   assign nib         = s3_nib_lo_ff ? ca[3:0] : ca[7:4];
   assign opaque      = cb != 8'd0;
   assign pal_rd_addr = four ? {s3_attr_hi_ff, nib} : (opaque ? cb : ca);
   assign pal_we      = adv && s3_valid_ff && s3_op_ff == OP_WR_PAL &&
                        s3_addr_ff < 16'(PALETTE_ENTRIES);

   tlpc_ram #(.WIDTH(16), .DEPTH(PALETTE_ENTRIES)) u_pal (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (s3_addr_ff[PAL_AW-1:0]),
      .wr_data (s3_wdata_ff),
      .rd_en   (adv),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_color)
   );

   logic        s4_valid_ff;
   logic        s4_render_ff;
   logic [15:0] s4_spr_ff;
   logic [9:0]  s4_x_ff;
   logic [8:0]  s4_y_ff;
   logic        s4_behind_ff;
   logic        s4_opaque_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_render_ff <= s3_op_ff == OP_RENDER;
         s4_spr_ff    <= s3_spr_ff;
         s4_behind_ff <= s3_behind_ff;
         s4_opaque_ff <= opaque;
         s4_x_ff      <= s3_x_ff;
         s4_y_ff      <= s3_y_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4: sprite priority
   // Sprite wins when present, unless (8-bit mode) it is behind an opaque layer 1.
   logic        spr_win;
   logic [15:0] color;
   logic [9:0]  rsp_x_ff;
   logic [8:0]  rsp_y_ff;
   logic [15:0] rsp_color_ff;

   assign spr_win = s4_spr_ff != 16'd0 && (four || !(s4_opaque_ff && s4_behind_ff));
   assign color   = spr_win ? s4_spr_ff : pal_color;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s4_valid_ff && s4_render_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_x_ff     <= s4_x_ff;
         rsp_y_ff     <= s4_y_ff;
         rsp_color_ff <= color;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_x       = rsp_x_ff;
   assign rsp_bus.out_y       = rsp_y_ff;
   assign rsp_bus.pixel_color = rsp_color_ff;

   // ---------------------------------------------------------------- checks
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s1_valid_ff) && $stable(s4_valid_ff))
      else $error("pipeline moved while stalled");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (adv && s4_valid_ff && !s4_render_ff) |=> !rsp_valid_ff)
      else $error("store write produced a response");

   a_sprite_wins: assert property (@(posedge clock) disable iff (reset)
      (adv && s4_valid_ff && s4_render_ff && spr_win) |=>
         (rsp_color_ff == $past(s4_spr_ff)))
      else $error("winning sprite color lost");

endmodule
